// ===== src/sfkh_pkg.sv =====
package sfkh_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [7:0]  CH_HASH   = 8'h23;
  localparam logic [7:0]  CH_NL     = 8'h0a;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_TAB    = 8'h09;
  localparam logic [7:0]  CH_VTAB   = 8'h0b;
  localparam logic [7:0]  CH_FF     = 8'h0c;
  localparam logic [7:0]  CH_CR     = 8'h0d;

  // work handed from the classifier to the hash unit
  typedef struct packed {
    logic       nl_first;  // mix a separator newline before the byte
    logic       mix_byte;  // mix data into the hash
    logic [7:0] data;
    logic       last;      // close the trace after this op
    logic [3:0] frames;    // frame count once this op is done
  } op_t;

  // one fnv-1a step; the prime 2^40 + 2^8 + 0xb3 is a sum of shifts
  function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== src/sfkh_front.sv =====
module sfkh_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       trace_byte,
  input  logic             last_byte,
  input  logic [3:0]       frame_cap,
  output logic             op_push,
  output sfkh_pkg::op_t    op
);

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_FRAME = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] count_r, count_nxt;
  logic       blank;
  logic       nl_first;
  logic       mix_byte;

  assign blank = (trace_byte == sfkh_pkg::CH_SPACE) || (trace_byte == sfkh_pkg::CH_TAB) ||
                 (trace_byte == sfkh_pkg::CH_VTAB)  || (trace_byte == sfkh_pkg::CH_FF)  ||
                 (trace_byte == sfkh_pkg::CH_CR);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    nl_first  = 1'b0;
    mix_byte  = 1'b0;
    if (trace_byte == sfkh_pkg::CH_NL) begin
      phase_nxt = PH_LEAD;
    end else begin
      case (phase_r)
        PH_LEAD: begin
          if (trace_byte == sfkh_pkg::CH_HASH) begin
            if (count_r < frame_cap) begin
              nl_first  = (count_r != 4'd0);
              mix_byte  = 1'b1;
              count_nxt = count_r + 4'd1;
              phase_nxt = PH_FRAME;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else if (!blank) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_FRAME: begin
          mix_byte = 1'b1;
        end
        default: begin
          // skipping to the end of the line
        end
      endcase
    end
  end

  assign op_push     = accept && (mix_byte || last_byte);
  assign op.nl_first = nl_first;
  assign op.mix_byte = mix_byte;
  assign op.data     = trace_byte;
  assign op.last     = last_byte;
  assign op.frames   = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      count_r <= 4'd0;
    end else if (accept) begin
      if (last_byte) begin
        phase_r <= PH_LEAD;
        count_r <= 4'd0;
      end else begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

// ===== src/sfkh_queue.sv =====
module sfkh_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  sfkh_pkg::op_t wr_op,
  output logic          q_full,
  input  logic          rd_en,
  output sfkh_pkg::op_t rd_op,
  output logic          q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfkh_pkg::op_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_op   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/sfkh_back.sv =====
module sfkh_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  sfkh_pkg::op_t op,
  output logic          q_pop,
  input  logic          out_pop,
  output logic          out_valid,
  output logic [63:0]   out_hash,
  output logic [3:0]    out_frames
);

  logic [63:0] hash_r, hash_nxt;
  logic        nl_done_r;
  logic        out_valid_r;
  logic [63:0] out_hash_r;
  logic [3:0]  out_frames_r;
  logic        need_nl;
  logic        slot_free;
  logic        step;
  logic [7:0]  mix_in;
  logic [63:0] mixed;

  assign need_nl   = op.nl_first && !nl_done_r;
  assign slot_free = !out_valid_r || out_pop;
  // a closing op waits for the result register
  assign step      = !q_empty && (need_nl || !op.last || slot_free);
  assign q_pop     = step && !need_nl;
  assign mix_in    = need_nl ? sfkh_pkg::CH_NL : op.data;
  assign mixed     = sfkh_pkg::fnv_mix(hash_r, mix_in);
  assign hash_nxt  = (need_nl || op.mix_byte) ? mixed : hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= sfkh_pkg::FNV_BASIS;
      nl_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step && !need_nl && op.last) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        if (need_nl) begin
          hash_r    <= hash_nxt;
          nl_done_r <= 1'b1;
        end else begin
          nl_done_r <= 1'b0;
          if (op.last) begin
            hash_r       <= sfkh_pkg::FNV_BASIS;
            out_hash_r   <= hash_nxt;
            out_frames_r <= op.frames;
          end else begin
            hash_r <= hash_nxt;
          end
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hash   = out_hash_r;
  assign out_frames = out_frames_r;

endmodule

// ===== src/stack_frame_key_hasher.sv =====
// channel   dir  handshake              payload
// input     in   push / full            in_trace_byte[7:0], in_last_byte
// result    out  empty / pop            out_trace_key[63:0], out_frames_found[3:0]
// config    in   psel/penable/pwrite    paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// at most one byte is taken per cycle while full is low; a '#' that opens any
// frame but the first costs the hash unit a separator newline mix, then the byte,
// the one fnv mixer being the limit
// with the hash unit caught up, a last byte passes the op queue and the result
// register to the out ports, after a newline mix if it opens a later frame
// rst_n is synchronous; the frame cap resets to 3, the hash to the fnv offset basis
// full rises when the op queue fills; the hash unit stalls only when a closing
// op finds the result register still occupied
module stack_frame_key_hasher #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_trace_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_trace_key,
  output logic [3:0]  out_frames_found,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]    frame_cap_r;
  logic          in_beat;
  logic          op_push;
  sfkh_pkg::op_t front_op;
  sfkh_pkg::op_t head_op;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          out_valid;

  // config register, word 0 only
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cap_r <= 4'd3;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      frame_cap_r <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {28'd0, frame_cap_r} : 32'd0;

  // front: classify bytes into hash ops
  assign full    = q_full;
  assign in_beat = push && !q_full;

  sfkh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_beat),
    .trace_byte  (in_trace_byte),
    .last_byte   (in_last_byte),
    .frame_cap   (frame_cap_r),
    .op_push     (op_push),
    .op          (front_op)
  );

  // decoupling queue between classifier and hash unit
  sfkh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (op_push),
    .wr_op   (front_op),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_op   (head_op),
    .q_empty (q_empty)
  );

  // back: fnv-1a mixing and the result register
  sfkh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .op         (head_op),
    .q_pop      (q_pop),
    .out_pop    (pop),
    .out_valid  (out_valid),
    .out_hash   (out_trace_key),
    .out_frames (out_frames_found)
  );

  assign empty = !out_valid;

  // a trace with no frames hashes nothing
  a_no_frame_basis: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_frames_found == 4'd0)) |-> (out_trace_key == sfkh_pkg::FNV_BASIS))
    else $error("frameless result differs from offset basis");

  // frame count stays within the configured cap
  a_frames_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_frames_found <= frame_cap_r))
    else $error("frames_found exceeds the frame cap");

  // a closing op leaves the queue only when the result register can take it
  a_close_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_op.last) |-> (empty || pop))
    else $error("result register overwritten");

endmodule
